FILE: sv/baro_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared constants, the queue word type and a helper function for the compensation block.
// ----------------------------------------------------------------------------
package baro_pkg;

   localparam int NumCal   = 5;
   localparam int CalIdxW  = 3;
   localparam int FifoDepth = 4;

   localparam logic [CalIdxW-1:0] CAL_AC1_AC2 = 3'd0;
   localparam logic [CalIdxW-1:0] CAL_AC3_AC4 = 3'd1;
   localparam logic [CalIdxW-1:0] CAL_AC5_AC6 = 3'd2;
   localparam logic [CalIdxW-1:0] CAL_B1_B2   = 3'd3;
   localparam logic [CalIdxW-1:0] CAL_MC_MD   = 3'd4;

   // front-end word as queued towards the arithmetic back end
   typedef struct packed {
      logic [15:0] ut;
      logic [23:0] up;
      logic [1:0]  oss;
   } item_type;

   // truncating signed division by 2^n
   function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
                                                    input int n);
      logic signed [31:0] bias;
      begin
         bias = a[31] ? ((32'sd1 <<< n) - 32'sd1) : 32'sd0;
         sdiv_pow2 = (a + bias) >>> n;
      end
   endfunction

endpackage
`default_nettype wire

FILE: sv/baro_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Barometric compensation
// Integer temperature and pressure compensation of a digital pressure sensor.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_ channel writes the five calibration words (index 0..4); other
//    indexes are ignored. Write only while idle. csr_ready is always high.
//  - req_ channel carries raw temperature, raw pressure bytes and the
//    oversampling setting; rsp_ returns temperature (0.1 C), pressure (Pa)
//    and a divide error flag (outputs zero when set).
//  - A front queue decouples acceptance from the arithmetic pipeline; the
//    back end is a 76-stage pipeline holding two 32-stage restoring
//    dividers and sustains one word per cycle while rsp_ready is high.
//  - When rsp_valid is high and rsp_ready is low the whole back pipeline
//    holds; the queue keeps accepting until full.
//  - Reset (synchronous) clears calibration, the queue and all valid bits.
// ----------------------------------------------------------------------------
module baro_compensation #(
   parameter int QueueDepth = baro_pkg::FifoDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_raw_temperature,
   input  wire logic [23:0] req_raw_pressure_bytes,
   input  wire logic [1:0]  req_oversampling,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_temperature_decidegrees,
   output logic [19:0]      rsp_pressure_pascal,
   output logic             rsp_divide_error
);
   import baro_pkg::*;

   logic [31:0] cal_ff [NumCal];
   item_type    in_word, q_word;
   logic        q_valid, q_ready;

   assign csr_ready = 1'b1;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumCal; i++) cal_ff[i] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CAL_AC1_AC2: cal_ff[0] <= csr_data;
            CAL_AC3_AC4: cal_ff[1] <= csr_data;
            CAL_AC5_AC6: cal_ff[2] <= csr_data;
            CAL_B1_B2:   cal_ff[3] <= csr_data;
            CAL_MC_MD:   cal_ff[4] <= csr_data;
            default: ;
         endcase
      end
   end

   assign in_word = '{ut: req_raw_temperature, up: req_raw_pressure_bytes,
                      oss: req_oversampling};

   baro_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_item(in_word),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_word)
   );

   baro_back u_back (
      .clock, .reset, .cal(cal_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_word),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_temp(rsp_temperature_decidegrees), .out_pres(rsp_pressure_pascal),
      .out_err(rsp_divide_error)
   );

   // error forces zero outputs
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |->
         rsp_temperature_decidegrees == '0 && rsp_pressure_pascal == '0)
      else $error("error word with non-zero payload");

   // stalled result stays valid and holds its pressure
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressure_pascal))
      else $error("result changed under stall");

   // no output during reset recovery
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

endmodule
`default_nettype wire

FILE: sv/baro_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts request words and queues them for the arithmetic back end.
// ----------------------------------------------------------------------------
module baro_front #(
   parameter int Depth = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire baro_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output baro_pkg::item_type     out_item
);
   import baro_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   item_type         mem [Depth];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and count update
   always_comb begin
      wr_in  = push ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

FILE: sv/baro_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Arithmetic back end
// Pipelined integer compensation: temperature, then pressure terms, with
// pipelined dividers for the two data-dependent divisions.
// ----------------------------------------------------------------------------
module baro_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [31:0]        cal [5],
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire baro_pkg::item_type in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic signed [15:0]      out_temp,
   output logic [19:0]             out_pres,
   output logic                    out_err
);
   import baro_pkg::*;

   // pipeline depth: 2 pre stages, 32 div-T, 5 mid, 32 div-P, 5 post
   localparam int NS = 76;

   logic              adv;
   logic [NS-1:0]     vld_ff;
   assign adv      = !out_valid || out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NS-2:0], in_valid};
   end

   // coefficients
   logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac5, ac6;
   logic [31:0]        ac4;
   assign ac1 = 32'(signed'(cal[0][31:16]));
   assign ac2 = 32'(signed'(cal[0][15:0]));
   assign ac3 = 32'(signed'(cal[1][31:16]));
   assign ac4 = {16'd0, cal[1][15:0]};
   assign ac5 = {16'd0, cal[2][31:16]};
   assign ac6 = {16'd0, cal[2][15:0]};
   assign b1  = 32'(signed'(cal[3][31:16]));
   assign b2  = 32'(signed'(cal[3][15:0]));
   assign mc  = 32'(signed'(cal[4][31:16]));
   assign md  = 32'(signed'(cal[4][15:0]));

   // ---------------- stage 0: X1 product
   logic signed [31:0] s0_p_ff;
   logic [23:0] s0_up_ff; logic [1:0] s0_oss_ff;
   always_ff @(posedge clock) if (adv) begin
      s0_p_ff   <= ({16'd0, in_item.ut} - ac6) * ac5;
      s0_up_ff  <= in_item.up >> (4'd8 - {2'd0, in_item.oss});
      s0_oss_ff <= in_item.oss;
   end
   // stage 1: x1, den, numerator
   logic signed [31:0] s1_x1_ff, s1_den_ff, s1_num_ff;
   logic [23:0] s1_up_ff; logic [1:0] s1_oss_ff;
   always_ff @(posedge clock) if (adv) begin
      s1_x1_ff  <= sdiv_pow2(s0_p_ff, 15);
      s1_den_ff <= sdiv_pow2(s0_p_ff, 15) + md;
      s1_num_ff <= mc <<< 11;
      s1_up_ff  <= s0_up_ff; s1_oss_ff <= s0_oss_ff;
   end

   // ---------------- signed divider T: 32 restoring stages on magnitudes
   localparam int DT = 32;
   logic [31:0] dt_r  [DT+1];
   logic [31:0] dt_q  [DT+1];
   logic [31:0] dt_d  [DT+1];
   logic [31:0] dt_n  [DT+1];
   logic        dt_ng [DT+1];
   logic signed [31:0] dt_x1 [DT+1];
   logic        dt_z  [DT+1];
   logic [23:0] dt_up [DT+1];
   logic [1:0]  dt_os [DT+1];
   always_comb begin
      dt_n[0]  = s1_num_ff[31] ? -s1_num_ff : s1_num_ff;
      dt_d[0]  = s1_den_ff[31] ? -s1_den_ff : s1_den_ff;
      dt_r[0]  = '0; dt_q[0] = '0;
      dt_ng[0] = s1_num_ff[31] ^ s1_den_ff[31];
      dt_x1[0] = s1_x1_ff; dt_z[0] = (s1_den_ff == '0);
      dt_up[0] = s1_up_ff; dt_os[0] = s1_oss_ff;
   end
   for (genvar g = 0; g < DT; g++) begin : g_dt
      logic [32:0] tr;
      assign tr = {dt_r[g], dt_n[g][31-g]};
      always_ff @(posedge clock) if (adv) begin
         if (tr >= {1'b0, dt_d[g]}) begin
            dt_r[g+1] <= 32'(tr - {1'b0, dt_d[g]});
            dt_q[g+1] <= dt_q[g] | (32'd1 << (31-g));
         end else begin
            dt_r[g+1] <= tr[31:0];
            dt_q[g+1] <= dt_q[g];
         end
         dt_n[g+1] <= dt_n[g]; dt_d[g+1] <= dt_d[g]; dt_ng[g+1] <= dt_ng[g];
         dt_x1[g+1] <= dt_x1[g]; dt_z[g+1] <= dt_z[g];
         dt_up[g+1] <= dt_up[g]; dt_os[g+1] <= dt_os[g];
      end
   end

   // ---------------- mid stages: B5, T, B6, pressure terms, B3, B4, B7
   logic signed [31:0] m0_b5_ff, m0_t_ff, m0_b6_ff;
   logic m0_z_ff; logic [23:0] m0_up_ff; logic [1:0] m0_os_ff;
   logic signed [31:0] x2t;
   assign x2t = dt_ng[DT] ? -dt_q[DT] : dt_q[DT];
   always_ff @(posedge clock) if (adv) begin
      m0_b5_ff <= dt_x1[DT] + x2t;
      m0_t_ff  <= sdiv_pow2(dt_x1[DT] + x2t + 32'sd8, 4);
      m0_b6_ff <= dt_x1[DT] + x2t - 32'sd4000;
      m0_z_ff  <= dt_z[DT]; m0_up_ff <= dt_up[DT]; m0_os_ff <= dt_os[DT];
   end
   // m1: b6*b6, ac2*b6, ac3*b6
   logic signed [31:0] m1_sqp_ff, m1_a2_ff, m1_a3_ff, m1_t_ff;
   logic m1_z_ff; logic [23:0] m1_up_ff; logic [1:0] m1_os_ff;
   always_ff @(posedge clock) if (adv) begin
      m1_sqp_ff <= m0_b6_ff * m0_b6_ff;
      m1_a2_ff  <= ac2 * m0_b6_ff;
      m1_a3_ff  <= ac3 * m0_b6_ff;
      m1_t_ff <= m0_t_ff;
      m1_z_ff <= m0_z_ff; m1_up_ff <= m0_up_ff; m1_os_ff <= m0_os_ff;
   end
   // m2: b2*sq, b1*sq
   logic signed [31:0] m2_bb2_ff, m2_bb1_ff, m2_a2_ff, m2_a3_ff, m2_t_ff;
   logic m2_z_ff; logic [23:0] m2_up_ff; logic [1:0] m2_os_ff;
   logic signed [31:0] sq;
   assign sq = sdiv_pow2(m1_sqp_ff, 12);
   always_ff @(posedge clock) if (adv) begin
      m2_bb2_ff <= b2 * sq;
      m2_bb1_ff <= b1 * sq;
      m2_a2_ff <= m1_a2_ff; m2_a3_ff <= m1_a3_ff; m2_t_ff <= m1_t_ff;
      m2_z_ff <= m1_z_ff; m2_up_ff <= m1_up_ff; m2_os_ff <= m1_os_ff;
   end
   // m3: B3 and the B4 multiplicand
   logic signed [31:0] m3_b3_ff, m3_x3_ff, m3_t_ff;
   logic m3_z_ff; logic [23:0] m3_up_ff; logic [1:0] m3_os_ff;
   logic signed [31:0] px3, b3s, qx3;
   always_comb begin
      px3 = sdiv_pow2(m2_bb2_ff, 11) + sdiv_pow2(m2_a2_ff, 11);
      b3s = ((ac1 <<< 2) + px3) <<< m2_os_ff;
      qx3 = sdiv_pow2(sdiv_pow2(m2_a3_ff, 13) + sdiv_pow2(m2_bb1_ff, 16) + 32'sd2, 2);
   end
   always_ff @(posedge clock) if (adv) begin
      m3_b3_ff <= sdiv_pow2(b3s + 32'sd2, 2);
      m3_x3_ff <= qx3 + 32'sd32768;
      m3_t_ff <= m2_t_ff;
      m3_z_ff <= m2_z_ff; m3_up_ff <= m2_up_ff; m3_os_ff <= m2_os_ff;
   end
   // m4: B4 and B7
   logic [31:0] m4_b4_ff, m4_b7_ff; logic signed [31:0] m4_t_ff;
   logic m4_z_ff;
   logic [31:0] b4p, b7v;
   always_comb begin
      b4p = ac4 * 32'(m3_x3_ff);
      b7v = ({8'd0, m3_up_ff} - 32'(m3_b3_ff)) * (32'd50000 >> m3_os_ff);
   end
   always_ff @(posedge clock) if (adv) begin
      m4_b4_ff <= b4p >> 15;
      m4_b7_ff <= b7v;
      m4_t_ff  <= m3_t_ff;
      m4_z_ff  <= m3_z_ff || ((b4p >> 15) == 32'd0);
   end

   // ---------------- unsigned divider P: 32 stages, plus doubling select
   localparam int DP = 32;
   logic [31:0] dp_r [DP+1], dp_q [DP+1], dp_d [DP+1], dp_n [DP+1];
   logic        dp_hi [DP+1], dp_z [DP+1];
   logic signed [31:0] dp_t [DP+1];
   always_comb begin
      dp_n[0]  = m4_b7_ff[31] ? m4_b7_ff : (m4_b7_ff << 1);
      dp_hi[0] = m4_b7_ff[31];
      dp_d[0] = m4_b4_ff; dp_r[0] = '0; dp_q[0] = '0;
      dp_z[0] = m4_z_ff; dp_t[0] = m4_t_ff;
   end
   for (genvar g = 0; g < DP; g++) begin : g_dp
      logic [32:0] tr;
      assign tr = {dp_r[g], dp_n[g][31-g]};
      always_ff @(posedge clock) if (adv) begin
         if (tr >= {1'b0, dp_d[g]}) begin
            dp_r[g+1] <= 32'(tr - {1'b0, dp_d[g]});
            dp_q[g+1] <= dp_q[g] | (32'd1 << (31-g));
         end else begin
            dp_r[g+1] <= tr[31:0];
            dp_q[g+1] <= dp_q[g];
         end
         dp_n[g+1] <= dp_n[g]; dp_d[g+1] <= dp_d[g]; dp_hi[g+1] <= dp_hi[g];
         dp_z[g+1] <= dp_z[g]; dp_t[g+1] <= dp_t[g];
      end
   end

   // ---------------- post stages
   logic signed [31:0] e0_p_ff, e0_t_ff; logic e0_z_ff;
   always_ff @(posedge clock) if (adv) begin
      e0_p_ff <= dp_hi[DP] ? (dp_q[DP] << 1) : dp_q[DP];
      e0_t_ff <= dp_t[DP]; e0_z_ff <= dp_z[DP];
   end
   logic signed [31:0] e1_sq_ff, e1_m_ff, e1_p_ff, e1_t_ff; logic e1_z_ff;
   logic signed [31:0] p8;
   assign p8 = sdiv_pow2(e0_p_ff, 8);
   always_ff @(posedge clock) if (adv) begin
      e1_sq_ff <= p8 * p8;
      e1_m_ff  <= -32'sd7357 * e0_p_ff;
      e1_p_ff <= e0_p_ff; e1_t_ff <= e0_t_ff; e1_z_ff <= e0_z_ff;
   end
   logic signed [31:0] e2_a_ff, e2_m_ff, e2_p_ff, e2_t_ff; logic e2_z_ff;
   always_ff @(posedge clock) if (adv) begin
      e2_a_ff <= e1_sq_ff * 32'sd3038;
      e2_m_ff <= e1_m_ff; e2_p_ff <= e1_p_ff; e2_t_ff <= e1_t_ff; e2_z_ff <= e1_z_ff;
   end
   logic signed [31:0] e3_p_ff, e3_t_ff; logic e3_z_ff;
   always_ff @(posedge clock) if (adv) begin
      e3_p_ff <= e2_p_ff + sdiv_pow2(sdiv_pow2(e2_a_ff, 16) + sdiv_pow2(e2_m_ff, 16)
                                     + 32'sd3791, 4);
      e3_t_ff <= e2_t_ff; e3_z_ff <= e2_z_ff;
   end
   // saturation and error forcing into the output register
   always_ff @(posedge clock) if (adv) begin
      if (e3_z_ff) begin
         out_temp <= '0; out_pres <= '0; out_err <= 1'b1;
      end else begin
         out_err <= 1'b0;
         if (e3_t_ff > 32'sd32767) out_temp <= 16'sh7fff;
         else if (e3_t_ff < -32'sd32768) out_temp <= 16'sh8000;
         else out_temp <= e3_t_ff[15:0];
         if (e3_p_ff < 0) out_pres <= '0;
         else if (e3_p_ff > 32'sd1048575) out_pres <= 20'hfffff;
         else out_pres <= e3_p_ff[19:0];
      end
   end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives raw temperature and pressure words with random gaps and back
// pressure, predicts each compensated result with 32-bit wrapping integer
// arithmetic, and checks every result word field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

   import baro_pkg::*;

   typedef struct packed {
      logic signed [15:0] temperature;
      logic [19:0]        pressure;
      logic               div_error;
   } reading_type;

   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_raw_temperature = '0;
   logic [23:0] req_raw_pressure_bytes = '0;
   logic [1:0] req_oversampling = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_temperature_decidegrees;
   logic [19:0] rsp_pressure_pascal;
   logic rsp_divide_error;

   // calibration words as the block should hold them
   logic [31:0] cal_word [NumCal];
   int unsigned cal_writes = 0;

   item_type pending_words[$];
   reading_type expected_readings[$];
   logic req_taken = 1'b0;
   logic quiet = 1'b0;          // no idling on either side
   logic hold_request = 1'b0;   // ask the receiver for a long hold-off
   int hold_cycles = 0;
   int mismatches = 0;
   int cycles = 0;

   baro_compensation uut (.*);

   always #5 clock = ~clock;

   // integer compensation with 32-bit wrap and truncating division
   function automatic reading_type compensate(input item_type w);
      reading_type r;
      int ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
      int x1, x2, x3, b3, b5, b6, t, p, den, sq;
      int unsigned ac4, b4, b7, up;
      r = '{temperature: '0, pressure: '0, div_error: 1'b1};
      ac1 = 32'($signed(cal_word[0][31:16]));
      ac2 = 32'($signed(cal_word[0][15:0]));
      ac3 = 32'($signed(cal_word[1][31:16]));
      ac4 = {16'd0, cal_word[1][15:0]};
      ac5 = {16'd0, cal_word[2][31:16]};
      ac6 = {16'd0, cal_word[2][15:0]};
      b1 = 32'($signed(cal_word[3][31:16]));
      b2 = 32'($signed(cal_word[3][15:0]));
      mc = 32'($signed(cal_word[4][31:16]));
      md = 32'($signed(cal_word[4][15:0]));
      ut = {16'd0, w.ut};
      up = {8'd0, w.up} >> (8 - w.oss);
      // temperature
      x1 = ((ut - ac6) * ac5) / 32768;
      den = x1 + md;
      if (den == 0) return r;
      x2 = (mc * 2048) / den;
      b5 = x1 + x2;
      t = (b5 + 8) / 16;
      // pressure
      b6 = b5 - 4000;
      sq = (b6 * b6) / 4096;
      x1 = (b2 * sq) / 2048;
      x2 = (ac2 * b6) / 2048;
      x3 = x1 + x2;
      b3 = ((ac1 * 4 + x3) * (32'sd1 << w.oss) + 2) / 4;
      x1 = (ac3 * b6) / 8192;
      x2 = (b1 * sq) / 65536;
      x3 = (x1 + x2 + 2) / 4;
      b4 = (ac4 * (x3 + 32768)) / 32'd32768;
      if (b4 == 0) return r;
      b7 = (up - b3) * (32'd50000 >> w.oss);
      if (b7 < 32'h8000_0000) p = (b7 * 2) / b4;
      else p = (b7 / b4) * 2;
      x1 = (p / 256) * (p / 256);
      x1 = (x1 * 3038) / 65536;
      x2 = (-7357 * p) / 65536;
      p = p + (x1 + x2 + 3791) / 16;
      r.temperature = (t > 32767) ? 16'sh7fff : (t < -32768) ? 16'sh8000 : t[15:0];
      r.pressure = (p < 0) ? 20'd0 : (p > 1048575) ? 20'hfffff : p[19:0];
      r.div_error = 1'b0;
      return r;
   endfunction

   // acceptance of calibration and request words
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index < NumCal) cal_word[csr_index] <= csr_data;
         cal_writes <= cal_writes + 1;
      end
      if (!reset && req_valid && req_ready) begin
         expected_readings.push_back(compensate({req_raw_temperature,
                                                 req_raw_pressure_bytes,
                                                 req_oversampling}));
         req_taken <= 1'b1;
      end
   end

   // request driver
   always @(negedge clock) begin
      item_type w;
      if (reset || !req_valid || req_taken) begin
         if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 29)) begin
            w = pending_words.pop_front();
            req_raw_temperature <= w.ut;
            req_raw_pressure_bytes <= w.up;
            req_oversampling <= w.oss;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken <= 1'b0;
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_request && hold_cycles == 0) hold_cycles <= 400;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && hold_cycles == 0 && (quiet || $urandom_range(99) >= 29);
   end

   // result checker
   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected result word");
         end else begin
            e = expected_readings.pop_front();
            if (rsp_temperature_decidegrees !== e.temperature ||
                rsp_pressure_pascal !== e.pressure ||
                rsp_divide_error !== e.div_error) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("mismatch: exp t=%0d p=%0d e=%0b got t=%0d p=%0d e=%0b",
                           e.temperature, e.pressure, e.div_error,
                           rsp_temperature_decidegrees, rsp_pressure_pascal,
                           rsp_divide_error);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_cal(input logic [2:0] idx, input logic [31:0] data);
      int unsigned n;
      n = cal_writes;
      @(negedge clock);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(negedge clock); while (cal_writes == n);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all_cal(input logic [31:0] a, b, c, d, e);
      write_cal(CAL_AC1_AC2, a);
      write_cal(CAL_AC3_AC4, b);
      write_cal(CAL_AC5_AC6, c);
      write_cal(CAL_B1_B2, d);
      write_cal(CAL_MC_MD, e);
   endtask

   task automatic queue_word(input logic [15:0] ut, input logic [23:0] up,
                             input logic [1:0] oss);
      pending_words.push_back({ut, up, oss});
   endtask

   // mostly plausible sensor readings, some fully random words
   task automatic queue_random(input int n);
      repeat (n) begin
         if ($urandom_range(99) < 75)
            queue_word(16'($urandom_range(34000, 22000)), 24'($urandom), 2'($urandom));
         else
            queue_word(16'($urandom), 24'($urandom), 2'($urandom));
      end
   endtask

   // wait for all words out, then let the pipeline drain
   task automatic drain;
      while (pending_words.size() > 0 || req_valid || expected_readings.size() > 0)
         @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   initial begin
      foreach (cal_word[i]) cal_word[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset calibration: temperature divisor is zero
      queue_word(16'd27898, 24'h5d2300, 2'd0);
      queue_word(16'hffff, 24'hffffff, 2'd3);
      drain();

      // typical calibration, writes to unused indexes, directed corners
      write_all_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
                    {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                    {-16'sd8711, 16'sd2868});
      write_cal(3'd5, 32'hdead_beef);
      write_cal(3'd7, 32'hffff_ffff);
      queue_word(16'd27898, {16'd23843, 8'd0}, 2'd0);
      queue_word(16'd0, 24'd0, 2'd0);
      queue_word(16'hffff, 24'hffffff, 2'd0);
      for (int o = 0; o < 4; o++) begin
         queue_word(16'd27898, 24'h5d2300, 2'(o));
         queue_word(16'h0000, 24'hffffff, 2'(o));
         queue_word(16'hffff, 24'h000000, 2'(o));
         queue_word(16'h8000, 24'h800000, 2'(o));
      end
      drain();
      queue_random(500);
      drain();

      // no idling, then a long receiver hold-off with the sender busy
      quiet <= 1'b1;
      queue_random(300);
      drain();
      quiet <= 1'b0;
      hold_request <= 1'b1;
      queue_random(200);
      @(negedge clock);
      hold_request <= 1'b0;
      drain();

      // zero pressure divisor: AC4 of zero
      write_cal(CAL_AC3_AC4, {-16'sd14383, 16'd0});
      queue_random(20);
      drain();

      // extreme calibration
      write_all_cal(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff);
      queue_random(60);
      drain();
      write_all_cal(32'h8000_7fff, 32'h7fff_8000, 32'h0000_ffff, 32'h8000_8000,
                    32'h7fff_0001);
      queue_random(60);
      drain();

      // random calibration sets
      repeat (8) begin
         write_all_cal($urandom, $urandom, $urandom, $urandom, $urandom);
         queue_random(60);
         drain();
      end

      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
